// File: hdl/ilr_pkg.sv
// Package for the image layer receiver: types, result kinds and header constants.
// No dependencies; used by ilr_step and image_layer_receiver_rle.
package ilr_pkg;

    localparam int LAYER_BYTES_DEF = 30720;
    localparam int MAX_PACKET_DEF  = 512;

    localparam logic [7:0] HDR_SYNC0   = 8'hAA;
    localparam logic [7:0] HDR_SYNC1   = 8'h55;
    localparam logic [9:0] HDR_MIN_LEN = 10'd10;
    localparam logic [9:0] POS_HOLD    = 10'd1023;
    localparam logic [6:0] LAYER_MASK  = 7'h7F;
    localparam int         RLE_FLAG_BIT = 7;

    typedef enum logic [1:0] {
        KIND_WRITE   = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_REFRESH = 2'd3
    } kind_t;

    // one result item; tlast travels beside it
    typedef struct packed {
        logic [7:0]  value;
        logic [8:0]  run_length;
        logic [14:0] address;
        logic        layer;
        kind_t       kind;
    } result_t;

    // up to three results caused by one input item
    typedef struct packed {
        logic [1:0]       count;
        result_t [2:0]    res;
    } bundle_t;

    typedef struct packed {
        logic [9:0]  byte_position;
        logic [7:0]  lead_byte;
        logic        packet_is_header;
        logic        packet_dropped;
        logic        header_valid;
        logic [7:0]  layer_count;
        logic        current_layer;
        logic        compressed_flag;
        logic [31:0] expected_size;
        logic [14:0] received_count;
        logic [14:0] decode_address;
        logic [8:0]  pending_count;
        logic [1:0]  layers_finished;
    } state_t;

endpackage

// File: hdl/ilr_step.sv
// Per-item next-state and result logic of the image layer receiver.
// Depends on ilr_pkg.
module ilr_step #(
    parameter int LAYER_BYTES = ilr_pkg::LAYER_BYTES_DEF,
    parameter int MAX_PACKET  = ilr_pkg::MAX_PACKET_DEF
) (
    input  ilr_pkg::state_t  state,
    input  logic [7:0]       rx_byte,
    input  logic [9:0]       packet_length,
    input  logic             end_of_packet,
    output ilr_pkg::state_t  state_next,
    output ilr_pkg::bundle_t results
);
    import ilr_pkg::*;

    localparam logic [14:0] LAYER_END = 15'(LAYER_BYTES);
    localparam logic [16:0] LAYER_END_W = 17'(LAYER_BYTES);
    localparam logic [10:0] PKT_END   = 11'(MAX_PACKET);

    always_comb
    begin
        state_t      st;
        logic [1:0]  n;
        logic [9:0]  pos;
        logic [14:0] room;
        logic [8:0]  run;
        logic [16:0] projected;

        st        = state;
        n         = 2'd0;
        results   = '0;
        pos       = state.byte_position;
        room      = LAYER_END - state.decode_address;
        run       = ({6'b0, state.pending_count} < room) ? state.pending_count : room[8:0];
        projected = {2'b0, state.received_count} + {7'b0, packet_length} - 17'd2;

        if (pos == 10'd0)
        begin
            st.lead_byte        = rx_byte;
            st.packet_is_header = 1'b0;
            st.packet_dropped   = 1'b0;
        end
        else if (pos == 10'd1)
        begin
            st.packet_is_header = (packet_length >= HDR_MIN_LEN) &&
                                  (state.lead_byte == HDR_SYNC0) && (rx_byte == HDR_SYNC1);
            if (!st.packet_is_header && state.header_valid && packet_length >= 10'd2 &&
                projected > LAYER_END_W)
                st.packet_dropped = 1'b1;
        end
        else if (state.packet_is_header)
        begin
            case (pos)
                10'd2: st.layer_count = rx_byte;
                10'd3:
                begin
                    st.compressed_flag = rx_byte[RLE_FLAG_BIT];
                    st.current_layer   = (rx_byte[6:0] & LAYER_MASK) != 7'd0;
                end
                10'd4: st.expected_size[7:0]   = rx_byte;
                10'd5: st.expected_size[15:8]  = rx_byte;
                10'd6: st.expected_size[23:16] = rx_byte;
                10'd7: st.expected_size[31:24] = rx_byte;
                default: ;
            endcase
        end
        else if (state.header_valid && !state.packet_dropped && pos < packet_length &&
                 {1'b0, pos} < PKT_END && state.received_count < LAYER_END)
        begin
            if (!state.compressed_flag)
            begin
                results.res[n] = '{value: rx_byte, run_length: 9'd1,
                                   address: state.received_count,
                                   layer: state.current_layer, kind: KIND_WRITE};
                n = n + 2'd1;
            end
            else if (state.pending_count == 9'd0)
            begin
                st.pending_count = {1'b0, rx_byte} + 9'd1;
            end
            else
            begin
                // value byte of a pair: decode the run, clipped at the layer end
                if (state.decode_address < LAYER_END)
                begin
                    results.res[n] = '{value: rx_byte, run_length: run,
                                       address: state.decode_address,
                                       layer: state.current_layer, kind: KIND_WRITE};
                    n = n + 2'd1;
                    st.decode_address = state.decode_address + {6'b0, run};
                end
                st.pending_count = 9'd0;
            end
            st.received_count = state.received_count + 15'd1;
        end

        if (end_of_packet)
        begin
            if (pos != 10'd0)
            begin
                if (st.packet_is_header)
                begin
                    if (pos >= 10'd9)
                    begin
                        st.received_count = '0;
                        st.decode_address = '0;
                        st.pending_count  = '0;
                        st.header_valid   = 1'b1;
                        results.res[n] = '{value: 8'd0, run_length: 9'd0, address: 15'd0,
                                           layer: st.current_layer, kind: KIND_ACK};
                        n = n + 2'd1;
                    end
                    else
                        st.header_valid = 1'b0;
                end
                else if (st.header_valid && packet_length >= 10'd2 &&
                         {17'b0, st.received_count} >= st.expected_size)
                begin
                    st.layers_finished[st.current_layer] = 1'b1;
                    st.header_valid = 1'b0;
                    results.res[n] = '{value: 8'd0, run_length: 9'd0, address: 15'd0,
                                       layer: st.current_layer, kind: KIND_DONE};
                    n = n + 2'd1;
                    if (st.layer_count == 8'd1 || st.layers_finished == 2'b11)
                    begin
                        results.res[n] = '{value: 8'd0, run_length: 9'd0, address: 15'd0,
                                           layer: 1'b0, kind: KIND_REFRESH};
                        n = n + 2'd1;
                        st.layers_finished = 2'b00;
                        st.layer_count     = 8'd0;
                    end
                end
            end
            st.byte_position    = 10'd0;
            st.packet_is_header = 1'b0;
            st.packet_dropped   = 1'b0;
        end
        else if (pos < POS_HOLD)
            st.byte_position = pos + 10'd1;

        results.count = n;
        state_next    = st;
    end

endmodule

// File: hdl/image_layer_receiver_rle.sv
// Image layer receiver with run-length decoding: top level, state and result queue.
// Depends on ilr_pkg and ilr_step.
// Output: an accepted byte's results are registered in the result queue, then offered.
// Throughput: one byte per cycle while the result queue is not full; a byte's results
// leave in order; the two-entry queue lets input continue while one result group waits.
// Reset (rst_n low, asynchronous) clears all receiver state and empties the queue.
module image_layer_receiver_rle #(
    parameter int LAYER_BYTES = ilr_pkg::LAYER_BYTES_DEF,
    parameter int MAX_PACKET  = ilr_pkg::MAX_PACKET_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // rx_byte[7:0], packet_length[17:8], zeros
    input  logic        s_axis_tlast,   // end_of_packet
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // kind[1:0], layer[2], address[17:3],
                                        // run_length[26:18], value[34:27], zeros
    output logic        m_axis_tlast    // last result of the input item
);
    import ilr_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    bundle_t    step_results;

    // two-entry queue of result groups, one group per item that produced results
    bundle_t    queue_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] sub_reg;

    bundle_t    head;
    result_t    head_res;
    logic       accept;
    logic       push;
    logic       out_fire;
    logic       pop;

    ilr_step #(
        .LAYER_BYTES (LAYER_BYTES),
        .MAX_PACKET  (MAX_PACKET)
    ) u_step (
        .state         (state_reg),
        .rx_byte       (s_axis_tdata[7:0]),
        .packet_length (s_axis_tdata[17:8]),
        .end_of_packet (s_axis_tlast),
        .state_next    (state_next),
        .results       (step_results)
    );

    assign s_axis_tready = (count_reg != 2'd2);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign push          = accept && (step_results.count != 2'd0);

    assign head          = queue_reg[rd_ptr_reg];
    assign head_res      = head.res[sub_reg];
    assign m_axis_tvalid = (count_reg != 2'd0);
    assign m_axis_tlast  = (sub_reg == head.count - 2'd1);
    assign m_axis_tdata  = {5'b0, head_res.value, head_res.run_length, head_res.address,
                            head_res.layer, head_res.kind};
    assign out_fire      = m_axis_tvalid && m_axis_tready;
    assign pop           = out_fire && m_axis_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            sub_reg    <= 2'd0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
            if (pop)
                sub_reg <= 2'd0;
            else if (out_fire)
                sub_reg <= sub_reg + 2'd1;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            queue_reg[wr_ptr_reg] <= step_results;
    end

endmodule

// File: tb/layer_write_checker.sv
`timescale 1ns / 100ps
// Result checker for image_layer_receiver_rle: follows accepted bytes, predicts result items
// and compares each delivered item against the oldest prediction. Depends on ilr_pkg.
module layer_write_checker #(
    parameter int LAYER_BYTES = ilr_pkg::LAYER_BYTES_DEF,
    parameter int MAX_PACKET  = ilr_pkg::MAX_PACKET_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // rx_byte[7:0], packet_length[17:8], zeros
    input  logic        s_axis_tlast,   // end_of_packet
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // kind[1:0], layer[2], address[17:3],
                                        // run_length[26:18], value[34:27], zeros
    input  logic        m_axis_tlast,   // last result of the input item
    output int          outstanding,
    output int          mismatches
);
    import ilr_pkg::*;

    typedef struct packed {
        logic    last;
        result_t res;
    } owed_t;

    owed_t       owed_q[$];
    int          err_count;

    // receiver state as predicted
    logic [9:0]  pos;
    logic [7:0]  first_byte;
    logic        in_header;
    logic        dropping;
    logic        armed;          // valid header seen, layer open
    logic [7:0]  layer_total;
    logic        layer_sel;
    logic        rle_mode;
    logic [31:0] size_goal;
    logic [14:0] taken;          // payload bytes accepted into the layer
    logic [14:0] write_ptr;      // next decoded offset
    logic [8:0]  held_run;       // run count plus one, 0 = none held
    logic [1:0]  done_mask;

    function automatic result_t make_result(kind_t k, logic l, logic [14:0] a,
                                            logic [8:0] n, logic [7:0] v);
        result_t r;
        r.kind       = k;
        r.layer      = l;
        r.address    = a;
        r.run_length = n;
        r.value      = v;
        return r;
    endfunction

    task automatic follow_byte(input logic [7:0] b, input logic [9:0] plen, input logic eop);
        result_t    batch[$];
        int         room;
        logic [8:0] run;
        if (pos == 10'd0) begin
            first_byte = b;
            in_header  = 1'b0;
            dropping   = 1'b0;
        end else if (pos == 10'd1) begin
            in_header = (plen >= HDR_MIN_LEN) && (first_byte == HDR_SYNC0) && (b == HDR_SYNC1);
            if (!in_header && armed && plen >= 10'd2 &&
                int'(taken) + int'(plen) - 2 > LAYER_BYTES)
                dropping = 1'b1;
        end else if (in_header) begin
            if (pos == 10'd2)
                layer_total = b;
            else if (pos == 10'd3) begin
                rle_mode  = b[RLE_FLAG_BIT];
                layer_sel = |(b[6:0] & LAYER_MASK);
            end else if (pos >= 10'd4 && pos <= 10'd7)
                size_goal[int'(pos - 10'd4) * 8 +: 8] = b;
        end else if (armed && !dropping && pos < plen && int'(pos) < MAX_PACKET &&
                     int'(taken) < LAYER_BYTES) begin
            if (!rle_mode)
                batch.push_back(make_result(KIND_WRITE, layer_sel, taken, 9'd1, b));
            else if (held_run == 9'd0)
                held_run = 9'(b) + 9'd1;
            else begin
                // runs are clipped at the layer end; nothing left means no write
                if (int'(write_ptr) < LAYER_BYTES) begin
                    room = LAYER_BYTES - int'(write_ptr);
                    run  = (int'(held_run) < room) ? held_run : 9'(room);
                    batch.push_back(make_result(KIND_WRITE, layer_sel, write_ptr, run, b));
                    write_ptr = write_ptr + 15'(run);
                end
                held_run = 9'd0;
            end
            taken = taken + 15'd1;
        end

        if (eop) begin
            if (pos >= 10'd1) begin
                if (in_header) begin
                    if (pos >= 10'd9) begin
                        taken     = '0;
                        write_ptr = '0;
                        held_run  = '0;
                        armed     = 1'b1;
                        batch.push_back(make_result(KIND_ACK, layer_sel, '0, '0, '0));
                    end else
                        armed = 1'b0;
                end else if (armed && plen >= 10'd2 && {17'd0, taken} >= size_goal) begin
                    done_mask[layer_sel] = 1'b1;
                    armed = 1'b0;
                    batch.push_back(make_result(KIND_DONE, layer_sel, '0, '0, '0));
                    if (layer_total == 8'd1 || done_mask == 2'b11) begin
                        batch.push_back(make_result(KIND_REFRESH, 1'b0, '0, '0, '0));
                        done_mask   = '0;
                        layer_total = '0;
                    end
                end
            end
            pos       = '0;
            in_header = 1'b0;
            dropping  = 1'b0;
        end else if (pos < POS_HOLD)
            pos = pos + 10'd1;

        foreach (batch[i])
            owed_q.push_back('{last: (i == batch.size() - 1), res: batch[i]});
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t got;
        owed_t   want;
        if (!rst_n) begin
            owed_q.delete();
            err_count   = 0;
            pos         = '0;
            first_byte  = '0;
            in_header   = 1'b0;
            dropping    = 1'b0;
            armed       = 1'b0;
            layer_total = '0;
            layer_sel   = 1'b0;
            rle_mode    = 1'b0;
            size_goal   = '0;
            taken       = '0;
            write_ptr   = '0;
            held_run    = '0;
            done_mask   = '0;
        end else begin
            // outputs first: an item accepted this edge cannot cause a result this edge
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[34:0];
                if (owed_q.size() == 0) begin
                    $error("unexpected result item: kind %0d address %0d", got.kind,
                           got.address);
                    err_count++;
                end else begin
                    want = owed_q.pop_front();
                    check_field("kind", want.res.kind, got.kind);
                    check_field("layer", want.res.layer, got.layer);
                    check_field("address", want.res.address, got.address);
                    check_field("run_length", want.res.run_length, got.run_length);
                    check_field("value", want.res.value, got.value);
                    check_field("last", want.last, m_axis_tlast);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                follow_byte(s_axis_tdata[7:0], s_axis_tdata[17:8], s_axis_tlast);
        end
        outstanding <= owed_q.size();
        mismatches  <= err_count;
    end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for image_layer_receiver_rle: clock, reset, packet stimulus, output stalls,
// watchdog and verdict. Depends on ilr_pkg, the receiver RTL and layer_write_checker.
module tb_top;
    import ilr_pkg::*;

    localparam int LAYER_BYTES  = LAYER_BYTES_DEF;
    localparam int MAX_PACKET   = MAX_PACKET_DEF;
    localparam int RANDOM_ITEMS = 130;
    localparam int FINAL_SCENES = 2;
    localparam int IDLE_LIMIT   = 1000;    // cycles with no item moving on either side
    localparam int TAIL_CYCLES  = 20;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;     // rx_byte[7:0], packet_length[17:8], zeros
    logic        s_axis_tlast  = 1'b0;   // end_of_packet
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // kind[1:0], layer[2], address[17:3],
                                         // run_length[26:18], value[34:27], zeros
    logic        m_axis_tlast;           // last result of the input item
    int          outstanding;
    int          mismatches;

    // 0 means no idling; otherwise one chance in idle_odds+1 per item/cycle of a burst
    int          idle_odds   = 0;
    int          stall_left  = 0;
    int          idle_cycles = 0;
    int          sent        = 0;
    logic [7:0]  pkt[$];                 // packet under construction

    image_layer_receiver_rle #(
        .LAYER_BYTES(LAYER_BYTES),
        .MAX_PACKET (MAX_PACKET)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    layer_write_checker #(
        .LAYER_BYTES(LAYER_BYTES),
        .MAX_PACKET (MAX_PACKET)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .outstanding  (outstanding),
        .mismatches   (mismatches)
    );

    always #5 clk = ~clk;

    // Result side back-pressure: random stall bursts while idle_odds is nonzero, driven at the falling edge.
    always @(negedge clk) begin
        if (idle_odds == 0)
            m_axis_tready <= 1'b1;
        else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, idle_odds) == 0) begin
            stall_left    <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else
            m_axis_tready <= 1'b1;
    end

    // Watchdog: ends the run when nothing moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // One byte item; an optional random gap goes before it.
    task automatic push_byte(input logic [7:0] b, input logic [9:0] plen, input logic eop);
        int gap;
        @(negedge clk);
        if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
            gap = $urandom_range(1, 8);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, plen, b};
        s_axis_tlast  <= eop;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent++;
    endtask

    // Sends pkt with end_of_packet on its final byte. Bytes 0..1 carry len_head (the one the
    // receiver classifies and drop-tests with), later bytes carry len_tail.
    task automatic ship(input logic [9:0] len_head, input logic [9:0] len_tail);
        for (int i = 0; i < pkt.size(); i++)
            push_byte(pkt[i], (i < 2) ? len_head : len_tail, i == pkt.size() - 1);
        pkt.delete();
    endtask

    // Header: sync, layer count, flag/layer byte, size LE, two spare bytes, optional extras.
    task automatic build_header(input logic [7:0] total, input logic [7:0] sel,
                                input logic [31:0] size, input int extra);
        pkt.push_back(HDR_SYNC0);
        pkt.push_back(HDR_SYNC1);
        pkt.push_back(total);
        pkt.push_back(sel);
        for (int i = 0; i < 4; i++)
            pkt.push_back(size[i * 8 +: 8]);
        repeat (2 + extra) pkt.push_back(8'($urandom));
    endtask

    // Data packet: two sequence bytes, then payload. In RLE mode even payload bytes are
    // run counts, mostly short; an odd payload leaves a dangling count byte.
    task automatic build_data(input int payload, input logic rle);
        repeat (2) pkt.push_back(8'($urandom));
        for (int i = 0; i < payload; i++)
            if (rle && i % 2 == 0 && $urandom_range(0, 3) != 0)
                pkt.push_back(8'($urandom_range(0, 7)));
            else
                pkt.push_back(8'($urandom));
    endtask

    // Well-formed layer transfer: header, then data packets until the size is reached,
    // sometimes abandoned early or sent with a wrong length field.
    task automatic layer_scene();
        logic        rle;
        logic [7:0]  sel;
        logic [7:0]  total;
        logic [31:0] goal;
        int          fed;
        int          chunk;
        rle = 1'($urandom_range(0, 1));
        sel = {rle, ($urandom_range(0, 1) == 1) ? 7'($urandom_range(1, 127)) : 7'd0};
        case ($urandom_range(0, 3))
            0:       total = 8'd1;
            1, 2:    total = 8'd2;
            default: total = 8'($urandom);
        endcase
        case ($urandom_range(0, 11))
            0:       goal = '0;
            1:       goal = $urandom;
            default: goal = 32'($urandom_range(1, 40));
        endcase
        build_header(total, sel, goal,
                     ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0);
        ship(10'(pkt.size()), 10'(pkt.size()));
        fed = 0;
        do begin
            chunk = $urandom_range(0, 16);
            build_data(chunk, rle);
            if ($urandom_range(0, 7) == 0)
                ship(10'($urandom_range(1, MAX_PACKET)), 10'($urandom_range(1, MAX_PACKET)));
            else
                ship(10'(pkt.size()), 10'(pkt.size()));
            fed += chunk;
        end while (32'(fed) < goal && $urandom_range(0, 9) != 0);
    endtask

    // Short junk packet, often starting with the header sync so it becomes a header,
    // truncated when it is shorter than ten bytes; the length field is random.
    task automatic noise_scene();
        int n;
        n = $urandom_range(1, 12);
        if ($urandom_range(0, 2) == 0)
        begin
            pkt.push_back(HDR_SYNC0);
            pkt.push_back(HDR_SYNC1);
        end
        while (pkt.size() < n)
            pkt.push_back(8'($urandom));
        ship(10'($urandom_range(1, MAX_PACKET)), 10'($urandom_range(1, MAX_PACKET)));
    endtask

    // Sender stops until every predicted result has been delivered.
    task automatic hold_until_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int base;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: one-byte packet, data before any header, truncated header,
        // then a raw two-byte layer that completes.
        idle_odds = 3;
        pkt.push_back(HDR_SYNC0);
        ship(10'd1, 10'd1);
        pkt.push_back(8'h01);
        pkt.push_back(8'h02);
        pkt.push_back(8'hFF);
        ship(10'd3, 10'd3);
        build_header(8'd2, 8'h80, 32'd5, 0);
        void'(pkt.pop_back());
        void'(pkt.pop_back());
        ship(10'd10, 10'd10);
        build_header(8'd2, 8'h00, 32'd2, 0);
        ship(10'd10, 10'd10);
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        pkt.push_back(8'h00);
        pkt.push_back(8'hFF);
        ship(10'd4, 10'd4);
        hold_until_drained();

        // RLE runs clipped at the layer end: a 100-byte run, 119 full runs, one clipped
        // run and one that finds no room left. Layer count 1 forces a refresh.
        build_header(8'd1, 8'hFF, 32'd244, 0);
        ship(10'd10, 10'd10);
        repeat (2) pkt.push_back(8'($urandom));
        pkt.push_back(8'd99);
        pkt.push_back(8'($urandom));
        repeat (121)
        begin
            pkt.push_back(8'hFF);
            pkt.push_back(8'($urandom));
        end
        ship(10'(pkt.size()), 10'(pkt.size()));
        hold_until_drained();

        // Random part: mostly complete layer transfers with random content, some junk.
        base = sent;
        while (sent - base < RANDOM_ITEMS)
        begin
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            case ($urandom_range(0, 9))
                0, 1:    noise_scene();
                2:
                begin
                    hold_until_drained();
                    layer_scene();
                end
                default: layer_scene();
            endcase
        end

        // Final part, no idling on either side: a few more layer transfers back to back.
        idle_odds = 0;
        repeat (FINAL_SCENES)
            layer_scene();

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
hdl/ilr_pkg.sv
hdl/ilr_step.sv
hdl/image_layer_receiver_rle.sv
tb/layer_write_checker.sv
tb/tb_top.sv
